// ===== rtl/csp_pkg.sv =====
`default_nettype none

package csp_pkg;

  localparam int FUNCTIONS = 256;
  localparam int ROWS      = 5;
  localparam int TAG_BITS  = 32;
  localparam int ARGS      = 4;

  localparam int FID_W     = 8;
  localparam int CNT_W     = 8;
  localparam int PORT_TAG_W = 32;
  localparam int FID_AW    = (FUNCTIONS > 1) ? $clog2(FUNCTIONS) : 1;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_CALLS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD = 1'b1;
  localparam logic [CFG_DW-1:0]    WARMUP_RST        = 8'd5;
  localparam logic [CFG_DW-1:0]    HIT_THR_RST       = 8'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [ARGS-1:0][TAG_BITS-1:0] tags_t;

  // one memory word holds the whole profile of one function
  typedef struct packed {
    logic [CNT_W-1:0]            wc;
    logic                        active;
    logic [ROWS-1:0][CNT_W-1:0]  cnt;
    logic [ROWS-1:0]             unused_pad;
    tags_t [ROWS-1:0]            tags;
  } csp_entry_t;

  localparam int ENTRY_W = $bits(csp_entry_t);

  typedef struct packed {
    logic  hit;
    tags_t tags;
  } hot_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } csp_state_t;

endpackage

`default_nettype wire

// ===== rtl/call_site_type_profiler.sv =====
`default_nettype none

// Call-site type profiler.
// Input channel (in_*): one transaction per profiled call, carrying the
// function number and four argument type tags. Output channel (out_*): one
// transaction each time a function's type combination reaches the hit
// threshold; most calls produce nothing. Configuration (cfg_*): a plain write
// port, index 0 = warm-up call count, index 1 = hit threshold; write it only
// while the block is idle.
// Each call is accepted in the idle state, whose edge reads the function's profile
// word from the single-port-per-direction profile RAM; the update step then writes
// the updated word back. The RAM read-modify-write sets the rate: no new call is
// taken until the last one is written back. A report is loaded at the write-back
// edge and shows on out_valid from then on.
// The output register holds a report while out_stall is high; new calls are
// still taken meanwhile, and only a call that itself produces a report waits
// in the update step until the register frees.
// Reset (rst_n low, synchronous) clears the per-function valid bits, so every
// profile reads as fresh without a clearing pass, and restores both
// configuration registers to 5.
module call_site_type_profiler (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [csp_pkg::FID_W-1:0]        in_function_id,
  input  wire logic [csp_pkg::PORT_TAG_W-1:0]   in_arg1_type,
  input  wire logic [csp_pkg::PORT_TAG_W-1:0]   in_arg2_type,
  input  wire logic [csp_pkg::PORT_TAG_W-1:0]   in_arg3_type,
  input  wire logic [csp_pkg::PORT_TAG_W-1:0]   in_arg4_type,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [csp_pkg::FID_W-1:0]             out_hot_function,
  output logic [csp_pkg::PORT_TAG_W-1:0]        out_hot_type1,
  output logic [csp_pkg::PORT_TAG_W-1:0]        out_hot_type2,
  output logic [csp_pkg::PORT_TAG_W-1:0]        out_hot_type3,
  output logic [csp_pkg::PORT_TAG_W-1:0]        out_hot_type4,
  input  wire logic                             cfg_wr_en,
  input  wire logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csp_pkg::CFG_DW-1:0]       cfg_wdata
);

  import csp_pkg::*;

  // configuration
  logic [CFG_DW-1:0] warmup_r;
  logic [CFG_DW-1:0] hit_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r  <= WARMUP_RST;
      hit_thr_r <= HIT_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WARMUP_CALLS:  warmup_r  <= cfg_wdata;
        CFG_HIT_THRESHOLD: hit_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  csp_state_t state_r, state_nxt;
  logic       in_acc;
  logic       upd_go;
  logic       blocked;
  logic       out_ld;
  logic       mem_we;

  logic [FID_W-1:0] fid_r;
  logic             range_r;
  logic             vld_rd_r;
  tags_t            tags_r;
  logic [FUNCTIONS-1:0] valid_r;

  logic [ENTRY_W-1:0] rd_data;
  csp_entry_t         entry_rd;
  csp_entry_t         entry_wr;
  hot_t               hot;

  logic             out_valid_r;
  logic [FID_W-1:0] out_fid_r;
  tags_t            out_tags_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // hold the update step while a new report has nowhere to go
  assign blocked = hot.hit && range_r && out_valid_r && out_stall;
  assign upd_go  = (state_r == ST_UPD) && !blocked;
  assign mem_we  = upd_go && range_r;
  assign out_ld  = mem_we && hot.hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the call; tags are kept at the stored width
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fid_r     <= in_function_id;
      range_r   <= ({1'b0, in_function_id} < (FID_W + 1)'(FUNCTIONS));
      vld_rd_r  <= valid_r[in_function_id[FID_AW-1:0]];
      tags_r[0] <= TAG_BITS'(in_arg1_type);
      tags_r[1] <= TAG_BITS'(in_arg2_type);
      tags_r[2] <= TAG_BITS'(in_arg3_type);
      tags_r[3] <= TAG_BITS'(in_arg4_type);
    end
  end

  // one valid bit per function stands in for a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[fid_r[FID_AW-1:0]] <= 1'b1;
    end
  end

  csp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FUNCTIONS),
    .AW    (FID_AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_function_id[FID_AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (fid_r[FID_AW-1:0]),
    .wr_data (entry_wr)
  );

  assign entry_rd = csp_entry_t'(rd_data);

  csp_upd u_upd (
    .entry_i     (entry_rd),
    .entry_vld_i (vld_rd_r),
    .tags_i      (tags_r),
    .warmup_i    (warmup_r),
    .hit_thr_i   (hit_thr_r),
    .entry_o     (entry_wr),
    .hot_o       (hot)
  );

  // output register: load a report, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_fid_r  <= fid_r;
      out_tags_r <= hot.tags;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hot_function = out_fid_r;
  assign out_hot_type1    = PORT_TAG_W'(out_tags_r[0]);
  assign out_hot_type2    = PORT_TAG_W'(out_tags_r[1]);
  assign out_hot_type3    = PORT_TAG_W'(out_tags_r[2]);
  assign out_hot_type4    = PORT_TAG_W'(out_tags_r[3]);

  // a call always reaches the update step right after it is taken
  a_acc_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_UPD))
    else $error("accepted call did not enter update step");

  // a report is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> (!out_valid_r || !out_stall))
    else $error("report overwritten in output register");

  // a written profile is marked valid afterwards
  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(fid_r[FID_AW-1:0])])
    else $error("profile written without valid bit");

  // the update step ends unless it is held by a waiting report
  a_upd_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPD) && !blocked) |=> (state_r == ST_IDLE))
    else $error("update step did not finish");

  // a held update step keeps its call
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPD) && blocked) |=> ($stable(fid_r) && $stable(tags_r)))
    else $error("held call changed");

endmodule

`default_nettype wire

// ===== rtl/csp_ram.sv =====
`default_nettype none

module csp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csp_upd.sv =====
`default_nettype none

module csp_upd (
  input  wire csp_pkg::csp_entry_t entry_i,
  input  wire logic                entry_vld_i,
  input  wire csp_pkg::tags_t      tags_i,
  input  wire logic [7:0]          warmup_i,
  input  wire logic [7:0]          hit_thr_i,
  output csp_pkg::csp_entry_t      entry_o,
  output csp_pkg::hot_t            hot_o
);

  import csp_pkg::*;

  csp_entry_t       ent;
  csp_entry_t       nxt;
  hot_t             hot;
  logic             done;
  logic [CNT_W-1:0] inc;

  always_comb begin
    // an entry never written reads as the reset profile
    ent = entry_vld_i ? entry_i : '0;
    nxt = ent;
    nxt.unused_pad = '0;
    hot = '0;
    done = 1'b0;
    inc = '0;
    if (ent.wc < warmup_i) begin
      nxt.wc = ent.wc + 8'd1;
    end else if (ent.wc == warmup_i) begin
      if (ent.wc != CNT_MAX) begin
        nxt.wc = ent.wc + 8'd1;
      end
      nxt.active = 1'b1;
      nxt.cnt    = '0;
    end else if (ent.active) begin
      // first empty or matching row wins
      for (int r = 0; r < ROWS; r++) begin
        inc = ent.cnt[r] + 8'd1;
        if (!done) begin
          if (ent.cnt[r] == '0) begin
            done        = 1'b1;
            nxt.cnt[r]  = 8'd1;
            nxt.tags[r] = tags_i;
          end else if (ent.tags[r] == tags_i) begin
            done = 1'b1;
            if (ent.cnt[r] != CNT_MAX) begin
              nxt.cnt[r] = inc;
              if (inc == hit_thr_i) begin
                hot.hit    = 1'b1;
                hot.tags   = ent.tags[r];
                nxt.active = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  assign entry_o = nxt;
  assign hot_o   = hot;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import csp_pkg::*;

  // primitive type tags; anything from FIRST_CLASS_ID up is a class id
  localparam logic [PORT_TAG_W-1:0] TAG_INT        = 32'd0;
  localparam logic [PORT_TAG_W-1:0] TAG_FLOAT      = 32'd1;
  localparam logic [PORT_TAG_W-1:0] TAG_BOOL       = 32'd2;
  localparam logic [PORT_TAG_W-1:0] TAG_UNDEFINED  = 32'd3;
  localparam logic [PORT_TAG_W-1:0] FIRST_CLASS_ID = 32'd4;

  localparam int IDLE_LIMIT  = 4000; // cycles with no transaction on either channel
  localparam int DRAIN_PAUSE = 12;   // covers the update step plus a held report

  // one call, or one report: a function number and its four argument tags
  typedef struct packed {
    logic [FID_W-1:0] function_id;
    tags_t            tags;        // tags[0] is the first argument
  } profile_call_t;

  // Fixed tag combinations for the opening sequence: all-zero, all-one, the
  // primitive types, a near-miss of that, alternating bits and a spare that
  // finds the table full.
  localparam tags_t DIRECTED_ROWS [6] = '{
    {4{32'h0000_0000}},
    {4{32'hFFFF_FFFF}},
    {TAG_UNDEFINED, TAG_BOOL, TAG_FLOAT, TAG_INT},
    {FIRST_CLASS_ID, TAG_BOOL, TAG_FLOAT, TAG_INT},
    {32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001, 32'h7FFF_FFFE},
    {4{TAG_FLOAT}}
  };

  // Predicts the hot-type reports from the accepted calls and checks the
  // reports that the block delivers, in order.
  class hot_call_scoreboard;
    logic [CFG_DW-1:0] warmup_calls;
    logic [CFG_DW-1:0] hit_threshold;
    logic [CNT_W-1:0]  warm_count [FUNCTIONS];
    bit                active     [FUNCTIONS];
    logic [CNT_W-1:0]  row_hits   [FUNCTIONS][ROWS];
    tags_t             row_tags   [FUNCTIONS][ROWS];
    profile_call_t     hot_q [$];
    int unsigned       errors;

    function new();
      warmup_calls  = WARMUP_RST;
      hit_threshold = HIT_THR_RST;
      errors        = 0;
      for (int f = 0; f < FUNCTIONS; f++) begin
        warm_count[f] = '0;
        active[f]     = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
          row_hits[f][r] = '0;
          row_tags[f][r] = '0;
        end
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_WARMUP_CALLS:  warmup_calls  = value;
        CFG_HIT_THRESHOLD: hit_threshold = value;
        default: ;
      endcase
    endfunction

    // profiling for this function is over unless warmup_calls is raised again
    function bit finished(logic [FID_W-1:0] fid);
      return !active[fid] && warm_count[fid] > warmup_calls;
    endfunction

    function int pending();
      return hot_q.size();
    endfunction

    function void note_call(profile_call_t c);
      int            f;
      profile_call_t hot;
      f = int'(c.function_id);
      if (f >= FUNCTIONS) return;
      // still warming up: count only
      if (warm_count[f] < warmup_calls) begin
        warm_count[f]++;
        return;
      end
      // this call activates a cleared table and is not recorded itself
      if (warm_count[f] == warmup_calls) begin
        if (warm_count[f] != CNT_MAX) warm_count[f]++;
        active[f] = 1'b1;
        for (int r = 0; r < ROWS; r++) begin
          row_hits[f][r] = '0;
          row_tags[f][r] = '0;
        end
        return;
      end
      if (!active[f]) return;
      // first empty row takes the tags, a matching row counts up
      for (int r = 0; r < ROWS; r++) begin
        if (row_hits[f][r] == '0) begin
          row_hits[f][r] = CNT_W'(1);
          row_tags[f][r] = c.tags;
          return;
        end
        if (row_tags[f][r] == c.tags) begin
          if (row_hits[f][r] == CNT_MAX) return;
          row_hits[f][r]++;
          if (row_hits[f][r] != hit_threshold) return;
          hot.function_id = c.function_id;
          hot.tags        = row_tags[f][r];
          hot_q.push_back(hot);
          active[f] = 1'b0;
          return;
        end
      end
      // full table and no match: drop the call
    endfunction

    function void check_report(profile_call_t got);
      profile_call_t want;
      if (hot_q.size() == 0) begin
        $error("report from function %0d with none pending", got.function_id);
        errors++;
        return;
      end
      want = hot_q.pop_front();
      if (got.function_id != want.function_id) begin
        $error("hot_function: expected %0d, got %0d", want.function_id, got.function_id);
        errors++;
      end
      for (int a = 0; a < ARGS; a++) begin
        if (got.tags[a] !== want.tags[a]) begin
          $error("hot_type%0d: expected %h, got %h", a + 1, want.tags[a], got.tags[a]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [FID_W-1:0]      in_function_id  = '0;
  logic [PORT_TAG_W-1:0] in_arg1_type    = '0;
  logic [PORT_TAG_W-1:0] in_arg2_type    = '0;
  logic [PORT_TAG_W-1:0] in_arg3_type    = '0;
  logic [PORT_TAG_W-1:0] in_arg4_type    = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [FID_W-1:0]      out_hot_function;
  logic [PORT_TAG_W-1:0] out_hot_type1;
  logic [PORT_TAG_W-1:0] out_hot_type2;
  logic [PORT_TAG_W-1:0] out_hot_type3;
  logic [PORT_TAG_W-1:0] out_hot_type4;
  logic                  cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = CFG_WARMUP_CALLS;
  logic [CFG_DW-1:0]     cfg_wdata       = '0;

  hot_call_scoreboard sb = new();

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver stall pattern: a mode held for a random window
  int stall_mode   = 0;
  int stall_window = 0;

  // working set of functions and tag combinations for the random part
  logic [FID_W-1:0] pool_fid    [8];
  int               pool_ncombo [8];
  tags_t            pool_combo  [8][8];

  int idle_cycles = 0;

  call_site_type_profiler DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_function_id   (in_function_id),
    .in_arg1_type     (in_arg1_type),
    .in_arg2_type     (in_arg2_type),
    .in_arg3_type     (in_arg3_type),
    .in_arg4_type     (in_arg4_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hot_function (out_hot_function),
    .out_hot_type1    (out_hot_type1),
    .out_hot_type2    (out_hot_type2),
    .out_hot_type3    (out_hot_type3),
    .out_hot_type4    (out_hot_type4),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Receiver: pick a stall mode for each window (never, light, heavy,
  // periodic) so held reports land on every phase of the update.
  always @(negedge clk) begin
    if (stall_window == 0) begin
      stall_mode   <= $urandom_range(0, 3);
      stall_window <= $urandom_range(16, 96);
    end else begin
      stall_window <= stall_window - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_window[2];
    endcase
  end

  // Monitor: sample both channels at the rising edge, feed accepted calls to
  // the predictor, check accepted reports, and run the watchdog.
  always @(posedge clk) begin : channel_monitor
    profile_call_t call_in;
    profile_call_t report_out;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        call_in.function_id = in_function_id;
        call_in.tags        = {in_arg4_type, in_arg3_type, in_arg2_type, in_arg1_type};
        sb.note_call(call_in);
      end
      if (out_valid && !out_stall) begin
        report_out.function_id = out_hot_function;
        report_out.tags        = {out_hot_type4, out_hot_type3, out_hot_type2, out_hot_type1};
        sb.check_report(report_out);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly primitive types and small class ids so combinations repeat, with
  // all-zero, all-one and full-range values mixed in.
  function automatic logic [PORT_TAG_W-1:0] random_tag();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(TAG_INT, TAG_UNDEFINED);
      1:       return $urandom;
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom_range(FIRST_CLASS_ID, 40);
    endcase
  endfunction

  // Present one call and hold it until accepted. Bursts of random length are
  // separated by random gaps with valid low.
  task automatic send_call(input logic [FID_W-1:0] fid, input tags_t tags);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_function_id <= fid;
    in_arg1_type   <= tags[0];
    in_arg2_type   <= tags[1];
    in_arg3_type   <= tags[2];
    in_arg4_type   <= tags[3];
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every pending report, then let an in-flight update
  // that reports nothing retire.
  task automatic drain_calls();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Reprogram both limits on an idle block.
  task automatic set_profile_limits(input logic [CFG_DW-1:0] warmup,
                                    input logic [CFG_DW-1:0] threshold);
    drain_calls();
    write_reg(CFG_WARMUP_CALLS, warmup);
    write_reg(CFG_HIT_THRESHOLD, threshold);
  endtask

  // Give a slot a new function and a set of combinations; later combinations
  // often differ from the previous one in a single argument.
  task automatic refill_slot(input int slot, input int max_combos);
    pool_fid[slot]    = FID_W'($urandom_range(0, FUNCTIONS - 1));
    pool_ncombo[slot] = $urandom_range(1, max_combos);
    for (int c = 0; c < pool_ncombo[slot]; c++) begin
      if (c > 0 && $urandom_range(0, 1) == 1) begin
        pool_combo[slot][c] = pool_combo[slot][c-1];
        pool_combo[slot][c][$urandom_range(0, ARGS - 1)] = random_tag();
      end else begin
        for (int a = 0; a < ARGS; a++) pool_combo[slot][c][a] = random_tag();
      end
    end
  endtask

  // Random calls: mostly repeated calls to a small working set of functions
  // so they warm up, fill their tables and report; the rest is noise to any
  // function with arbitrary tags. Slots whose function is done get a new one.
  task automatic run_phase(input int n_calls, input int pool_size, input int max_combos,
                           input bit keep_pool, input int noise_pct);
    int    slot;
    tags_t noise_tags;
    if (!keep_pool) begin
      for (int s = 0; s < pool_size; s++) refill_slot(s, max_combos);
    end
    for (int k = 0; k < n_calls; k++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        for (int a = 0; a < ARGS; a++) noise_tags[a] = $urandom;
        send_call(FID_W'($urandom_range(0, FUNCTIONS - 1)), noise_tags);
      end else begin
        slot = $urandom_range(0, pool_size - 1);
        if (sb.finished(pool_fid[slot])) refill_slot(slot, max_combos);
        send_call(pool_fid[slot],
                  pool_combo[slot][$urandom_range(0, pool_ncombo[slot] - 1)]);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset limits (5 warm-up calls, threshold 5): warm up
    // the top function, activate it, fill all rows, hit a full table with a
    // new combination, report the all-one row, then call the finished
    // function again. Function 0 then warms up and records one row.
    repeat (5) send_call(8'hFF, DIRECTED_ROWS[4]);
    send_call(8'hFF, DIRECTED_ROWS[1]);
    for (int i = 0; i < 6; i++) send_call(8'hFF, DIRECTED_ROWS[i]);
    repeat (4) send_call(8'hFF, DIRECTED_ROWS[1]);
    send_call(8'hFF, DIRECTED_ROWS[1]);
    repeat (6) send_call(8'h00, DIRECTED_ROWS[0]);
    send_call(8'h00, DIRECTED_ROWS[2]);

    run_phase(350, 4, 3, 1'b0, 10);

    // lowest limits: activate on the first call, report on the second hit
    set_profile_limits(8'd0, 8'd2);
    run_phase(350, 6, 7, 1'b0, 10);

    // highest limits: one function driven through the full warm-up and count
    set_profile_limits(8'd254, 8'd255);
    run_phase(560, 1, 1, 1'b0, 2);

    // build up a row far below a high threshold ...
    set_profile_limits(8'd1, 8'd255);
    run_phase(200, 1, 1, 1'b0, 0);

    // ... then drop the threshold below its count and push it into saturation
    set_profile_limits(8'd1, 8'd2);
    run_phase(120, 1, 1, 1'b1, 0);

    // raised warm-up reactivates old tables of the functions seen so far
    set_profile_limits(8'd9, 8'd3);
    run_phase(250, 6, 7, 1'b0, 10);

    drain_calls();
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
